// ===== design/dlst_pkg.sv =====
// Shared types and constants for the dual-list task scheduler.
// No dependencies; used by the controller, datapath, top level and checker.
package dlst_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_NONE   = 3'd2,
    ST_ZERO   = 3'd3,
    ST_NOKIND = 3'd4
  } status_t;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_NEXT_I,
    OP_ALLOC,
    OP_LIST_INIT,
    OP_ORD_RD,
    OP_ENT_RD,
    OP_MUL,
    OP_SET_POS,
    OP_SH_RD,
    OP_SH_WR,
    OP_INS_FIN,
    OP_POP_CHK,
    OP_REM_FOUND,
    OP_RS_RD,
    OP_RS_WR,
    OP_REM_FIN,
    OP_FREE,
    OP_RESULT
  } op_t;

  // List selectors
  localparam logic LIST_CPU = 1'b0;
  localparam logic LIST_GPU = 1'b1;

  // Word layout widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // Command from controller to datapath
  typedef struct packed {
    op_t     op;
    logic    lsel;
    status_t st;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_pop;
    logic pop_gpu;
    logic bad_score;
    logic no_kind;
    logic can_cpu;
    logic can_gpu;
    logic used_i;
    logic i_last;
    logic i_eq_n;
    logic key_gt;
    logic j_eq_pos;
    logic j1_eq_n;
    logic ord_match;
    logic pop_ok;
    logic dev_hit;
    logic kind_cpu;
    logic kind_gpu;
    logic out_busy;
  } stat_t;

endpackage

// ===== design/dual_list_speedup_task_scheduler_top.sv =====
// Top level of the dual-list task scheduler: controller, datapath and stream ports.
// Depends on dlst_pkg, dlst_ctrl, dlst_dp (and dlst_ram through the datapath).
//
// One word at a time: a push or pop is accepted only while the scheduler is idle
// and returns exactly one result word; a finished result may wait on out_tready
// while the next word is taken. A push scans for the first free slot, then for
// each of its lists walks the order list to the insert point and shifts the
// tail up by one; a granted pop checks the head entry's device mask and then
// removes its slot from each list it is in. A result waits while the previous
// result word is still stalled. The walk and shift go through the order RAM,
// one registered read per step.
module dual_list_speedup_task_scheduler_top #(
  parameter int CAPACITY    = 16,
  parameter int NUM_DEVICES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: task_id[7:0], cpu_score[23:8], gpu_score[39:24], can_cpu[40],
  //        can_gpu[41], device_mask[49:42], pop_on_gpu[50], device_id[53:51]
  input  logic [dlst_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: mode (0 push, 1 pop)
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: granted[0], task_out[8:1], status[11:9], cpu_len[16:12],
  //        gpu_len[21:17], idle[22]
  output logic [dlst_pkg::OUT_DATA_W-1:0] out_tdata
);

  dlst_pkg::ctrl_t ctrl;
  dlst_pkg::stat_t stat;

  dlst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  dlst_dp #(.CAPACITY(CAPACITY), .NUM_DEVICES(NUM_DEVICES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== design/dlst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dlst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== design/dlst_dp.sv =====
// Datapath: item registers, entry store, order lists, key multipliers, result word.
// Depends on dlst_pkg and dlst_ram.
module dlst_dp #(
  parameter int CAPACITY    = 16,
  parameter int NUM_DEVICES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [dlst_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  dlst_pkg::ctrl_t                 ctrl,
  output dlst_pkg::stat_t                 stat,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dlst_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int IW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int EW     = 50;
  localparam int ODEPTH = 2 * (1 << IW);

  // Item registers
  logic        mode_r;
  logic [7:0]  tid_r;
  logic [15:0] cs_r, gs_r;
  logic        cc_r, cg_r;
  logic [7:0]  mask_r;
  logic        pg_r;
  logic [2:0]  dev_r;

  // Control and working registers
  logic [CW-1:0]       ccnt_r, gcnt_r;
  logic [CAPACITY-1:0] used_r;
  logic [CW-1:0]       i_r, j_r, pos_r;
  logic [IW-1:0]       slot_r, head_r;
  logic                lsel_r;
  logic [31:0]         p1_r, p2_r;
  logic [7:0]          task_r;
  logic [1:0]          kinds_r;
  logic                out_valid_r;
  logic [dlst_pkg::OUT_DATA_W-1:0] out_data_r;

  // RAM ports
  logic          ent_we;
  logic [EW-1:0] ent_wdata, ent_rdata;
  logic          ord_we;
  logic [IW:0]   ord_waddr, ord_raddr;
  logic [IW-1:0] ord_wdata, ord_rdata;

  logic [CW-1:0] n_l, jm1, jp1;
  logic [7:0]    e_task, e_dev;
  logic [15:0]   e_cs, e_gs;
  logic [1:0]    e_kinds;
  logic [15:0]   ka, kb, kc, kd;
  logic          granted;

  assign n_l = lsel_r ? gcnt_r : ccnt_r;
  assign jm1 = j_r - 1'b1;
  assign jp1 = j_r + 1'b1;

  assign e_task  = ent_rdata[7:0];
  assign e_cs    = ent_rdata[23:8];
  assign e_gs    = ent_rdata[39:24];
  assign e_dev   = ent_rdata[47:40];
  assign e_kinds = ent_rdata[49:48];

  // GPU key is cpu/gpu, CPU key is gpu/cpu
  assign ka = lsel_r ? cs_r : gs_r;
  assign kb = lsel_r ? gs_r : cs_r;
  assign kc = lsel_r ? e_cs : e_gs;
  assign kd = lsel_r ? e_gs : e_cs;

  // Entry store: task, cpu score, gpu score, devices, kinds
  assign ent_we    = (ctrl.op == dlst_pkg::OP_ALLOC);
  assign ent_wdata = {cg_r, cc_r, mask_r, gs_r, cs_r, tid_r};

  dlst_ram #(.WIDTH(EW), .DEPTH(1 << IW)) u_ent (
    .clk   (clk),
    .we    (ent_we),
    .waddr (i_r[IW-1:0]),
    .wdata (ent_wdata),
    .raddr (ord_rdata),
    .rdata (ent_rdata)
  );

  // Order store addressing: {list, position}
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = {lsel_r, j_r[IW-1:0]};
    ord_wdata = ord_rdata;
    ord_raddr = {lsel_r, i_r[IW-1:0]};
    unique case (ctrl.op)
      dlst_pkg::OP_SH_RD: ord_raddr = {lsel_r, jm1[IW-1:0]};
      dlst_pkg::OP_RS_RD: ord_raddr = {lsel_r, jp1[IW-1:0]};
      dlst_pkg::OP_SH_WR,
      dlst_pkg::OP_RS_WR: ord_we = 1'b1;
      dlst_pkg::OP_INS_FIN: begin
        ord_we    = 1'b1;
        ord_waddr = {lsel_r, pos_r[IW-1:0]};
        ord_wdata = slot_r;
      end
      default: ;
    endcase
  end

  dlst_ram #(.WIDTH(IW), .DEPTH(ODEPTH)) u_ord (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // Payload and working registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      dlst_pkg::OP_LOAD: begin
        mode_r <= in_tuser;
        tid_r  <= in_tdata[7:0];
        cs_r   <= in_tdata[23:8];
        gs_r   <= in_tdata[39:24];
        cc_r   <= in_tdata[40];
        cg_r   <= in_tdata[41];
        mask_r <= in_tdata[49:42];
        pg_r   <= in_tdata[50];
        dev_r  <= in_tdata[53:51];
        i_r    <= '0;
        task_r <= '0;
      end
      dlst_pkg::OP_NEXT_I:    i_r <= i_r + 1'b1;
      dlst_pkg::OP_ALLOC:     slot_r <= i_r[IW-1:0];
      dlst_pkg::OP_LIST_INIT: begin
        lsel_r <= ctrl.lsel;
        i_r    <= '0;
      end
      dlst_pkg::OP_ENT_RD:    head_r <= ord_rdata;
      dlst_pkg::OP_MUL: begin
        p1_r <= ka * kd;
        p2_r <= kc * kb;
      end
      dlst_pkg::OP_SET_POS: begin
        pos_r <= i_r;
        j_r   <= n_l;
      end
      dlst_pkg::OP_SH_WR:     j_r <= jm1;
      dlst_pkg::OP_RS_WR:     j_r <= jp1;
      dlst_pkg::OP_REM_FOUND: j_r <= i_r;
      dlst_pkg::OP_POP_CHK: begin
        kinds_r <= e_kinds;
        if (stat.dev_hit) begin
          task_r <= e_task;
        end
      end
      dlst_pkg::OP_RESULT: begin
        out_data_r <= {1'b0, gcnt_r == '0 && ccnt_r == '0, 5'(gcnt_r), 5'(ccnt_r),
                       ctrl.st, task_r, granted};
      end
      default: ;
    endcase
  end

  assign granted = (ctrl.st == dlst_pkg::ST_OK);

  // Counts, used bits, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r      <= '0;
      gcnt_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.op == dlst_pkg::OP_ALLOC) begin
        used_r[i_r[IW-1:0]] <= 1'b1;
      end
      if (ctrl.op == dlst_pkg::OP_FREE) begin
        used_r[head_r] <= 1'b0;
      end
      if (ctrl.op == dlst_pkg::OP_INS_FIN) begin
        if (lsel_r) gcnt_r <= gcnt_r + 1'b1;
        else        ccnt_r <= ccnt_r + 1'b1;
      end
      if (ctrl.op == dlst_pkg::OP_REM_FIN) begin
        if (lsel_r) gcnt_r <= gcnt_r - 1'b1;
        else        ccnt_r <= ccnt_r - 1'b1;
      end
      if (ctrl.op == dlst_pkg::OP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Status toward the controller
  always_comb begin
    stat.is_pop    = mode_r;
    stat.pop_gpu   = pg_r;
    stat.bad_score = (cs_r == '0) || (gs_r == '0);
    stat.no_kind   = !cc_r && !cg_r;
    stat.can_cpu   = cc_r;
    stat.can_gpu   = cg_r;
    stat.used_i    = used_r[i_r[IW-1:0]];
    stat.i_last    = (i_r == CW'(CAPACITY - 1));
    stat.i_eq_n    = (i_r == n_l);
    stat.key_gt    = (p1_r > p2_r);
    stat.j_eq_pos  = (j_r == pos_r);
    stat.j1_eq_n   = (jp1 == n_l);
    stat.ord_match = (ord_rdata == head_r);
    stat.pop_ok    = ((pg_r ? gcnt_r : ccnt_r) != '0) && (32'(dev_r) < NUM_DEVICES);
    stat.dev_hit   = e_dev[dev_r];
    stat.kind_cpu  = kinds_r[0];
    stat.kind_gpu  = kinds_r[1];
    stat.out_busy  = out_valid_r && !out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/dlst_ctrl.sv =====
// Controller: sequences push (scan, allocate, ordered insert) and pop (check, remove).
// Depends on dlst_pkg.
module dlst_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  dlst_pkg::stat_t stat,
  output dlst_pkg::ctrl_t ctrl
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_SCAN, S_INS_INIT, S_I_ORD, S_I_ENT, S_I_MUL, S_I_CMP,
    S_SH, S_SH_WR, S_P_ORD, S_P_ENT, S_P_CHK, S_R_INIT, S_R_INIT_G, S_R_RD,
    S_R_CMP, S_RS, S_RS_WR, S_FREE, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic                cur_r, cur_nxt;
  dlst_pkg::status_t   st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= dlst_pkg::LIST_CPU;
      st_r    <= dlst_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    st_nxt    = st_r;
    ctrl.op   = dlst_pkg::OP_NONE;
    ctrl.lsel = cur_r;
    ctrl.st   = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctrl.op   = dlst_pkg::OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_pop) begin
          if (stat.pop_ok) begin
            ctrl.op   = dlst_pkg::OP_LIST_INIT;
            ctrl.lsel = stat.pop_gpu;
            state_nxt = S_P_ORD;
          end else begin
            st_nxt    = dlst_pkg::ST_NONE;
            state_nxt = S_DONE;
          end
        end else if (stat.bad_score) begin
          st_nxt    = dlst_pkg::ST_ZERO;
          state_nxt = S_DONE;
        end else if (stat.no_kind) begin
          st_nxt    = dlst_pkg::ST_NOKIND;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      // Find the first free entry
      S_SCAN: begin
        if (!stat.used_i) begin
          ctrl.op   = dlst_pkg::OP_ALLOC;
          cur_nxt   = stat.can_gpu ? dlst_pkg::LIST_GPU : dlst_pkg::LIST_CPU;
          state_nxt = S_INS_INIT;
        end else if (stat.i_last) begin
          st_nxt    = dlst_pkg::ST_FULL;
          state_nxt = S_DONE;
        end else begin
          ctrl.op = dlst_pkg::OP_NEXT_I;
        end
      end
      // Ordered insert: walk until the new key is strictly greater or the list ends
      S_INS_INIT: begin
        ctrl.op   = dlst_pkg::OP_LIST_INIT;
        state_nxt = S_I_ORD;
      end
      S_I_ORD: begin
        if (stat.i_eq_n) begin
          ctrl.op   = dlst_pkg::OP_SET_POS;
          state_nxt = S_SH;
        end else begin
          ctrl.op   = dlst_pkg::OP_ORD_RD;
          state_nxt = S_I_ENT;
        end
      end
      S_I_ENT: begin
        ctrl.op   = dlst_pkg::OP_ENT_RD;
        state_nxt = S_I_MUL;
      end
      S_I_MUL: begin
        ctrl.op   = dlst_pkg::OP_MUL;
        state_nxt = S_I_CMP;
      end
      S_I_CMP: begin
        if (stat.key_gt) begin
          ctrl.op   = dlst_pkg::OP_SET_POS;
          state_nxt = S_SH;
        end else begin
          ctrl.op   = dlst_pkg::OP_NEXT_I;
          state_nxt = S_I_ORD;
        end
      end
      // Shift the tail up by one, then drop the slot in
      S_SH: begin
        if (stat.j_eq_pos) begin
          ctrl.op = dlst_pkg::OP_INS_FIN;
          if (cur_r == dlst_pkg::LIST_GPU && stat.can_cpu) begin
            cur_nxt   = dlst_pkg::LIST_CPU;
            state_nxt = S_INS_INIT;
          end else begin
            st_nxt    = dlst_pkg::ST_OK;
            state_nxt = S_DONE;
          end
        end else begin
          ctrl.op   = dlst_pkg::OP_SH_RD;
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ctrl.op   = dlst_pkg::OP_SH_WR;
        state_nxt = S_SH;
      end
      // Pop: read head, then its entry
      S_P_ORD: begin
        ctrl.op   = dlst_pkg::OP_ORD_RD;
        state_nxt = S_P_ENT;
      end
      S_P_ENT: begin
        ctrl.op   = dlst_pkg::OP_ENT_RD;
        state_nxt = S_P_CHK;
      end
      S_P_CHK: begin
        ctrl.op = dlst_pkg::OP_POP_CHK;
        if (stat.dev_hit) begin
          state_nxt = S_R_INIT;
        end else begin
          st_nxt    = dlst_pkg::ST_NONE;
          state_nxt = S_DONE;
        end
      end
      // Remove head slot from each list it is in, CPU list first
      S_R_INIT: begin
        ctrl.op   = dlst_pkg::OP_LIST_INIT;
        ctrl.lsel = stat.kind_cpu ? dlst_pkg::LIST_CPU : dlst_pkg::LIST_GPU;
        cur_nxt   = ctrl.lsel;
        state_nxt = S_R_RD;
      end
      // Second pass over the GPU list
      S_R_INIT_G: begin
        ctrl.op   = dlst_pkg::OP_LIST_INIT;
        state_nxt = S_R_RD;
      end
      S_R_RD: begin
        ctrl.op   = dlst_pkg::OP_ORD_RD;
        state_nxt = S_R_CMP;
      end
      S_R_CMP: begin
        if (stat.ord_match) begin
          ctrl.op   = dlst_pkg::OP_REM_FOUND;
          state_nxt = S_RS;
        end else begin
          ctrl.op   = dlst_pkg::OP_NEXT_I;
          state_nxt = S_R_RD;
        end
      end
      S_RS: begin
        if (stat.j1_eq_n) begin
          ctrl.op = dlst_pkg::OP_REM_FIN;
          if (cur_r == dlst_pkg::LIST_CPU && stat.kind_gpu) begin
            cur_nxt   = dlst_pkg::LIST_GPU;
            state_nxt = S_R_INIT_G;
          end else begin
            state_nxt = S_FREE;
          end
        end else begin
          ctrl.op   = dlst_pkg::OP_RS_RD;
          state_nxt = S_RS_WR;
        end
      end
      S_RS_WR: begin
        ctrl.op   = dlst_pkg::OP_RS_WR;
        state_nxt = S_RS;
      end
      S_FREE: begin
        ctrl.op   = dlst_pkg::OP_FREE;
        st_nxt    = dlst_pkg::ST_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          ctrl.op   = dlst_pkg::OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== design/dlst_checker.sv =====
// Port-level checker for the dual-list task scheduler, bound to the top level.
// Depends on dlst_pkg and dual_list_speedup_task_scheduler_top.
module dlst_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dlst_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // One word in flight: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // granted exactly when status is ok
  a_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[11:9] == dlst_pkg::ST_OK)))
    else $error("granted disagrees with status");

  // idle exactly when both lengths are zero
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[22] == (out_tdata[21:12] == 10'd0)))
    else $error("idle flag disagrees with lengths");

  // no task id without a grant
  a_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[8:1] == 8'd0)
    else $error("task id on failed item");

endmodule

bind dual_list_speedup_task_scheduler_top dlst_checker u_dlst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
